FILE: design/bdrc_pkg.sv
// Shared types and constants for the beat detector and rate calculator.
package bdrc_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int CSR_DATA_W        = 16;
   localparam int CSR_INDEX_W       = 2;
   localparam int RATE_W            = 15;
   localparam int RATE_NUMERATOR    = 24000;
   localparam int DEF_BEATS_PER_WIN = 4;
   localparam int DEF_TICK_BITS     = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_HIGH_TICKS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HIGH_TICKS  = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] UPPER_RESET = 16'sd50;
   localparam logic signed [SAMPLE_W-1:0] LOWER_RESET = -16'sd100;
   localparam logic [CSR_DATA_W-1:0]      MIN_RESET   = 16'd19;
   localparam logic [CSR_DATA_W-1:0]      MAX_RESET   = 16'd201;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_WIN,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              beat;
      logic              beat_ok;
      logic              rate_ready;
      logic [RATE_W-1:0] rate;
   } result_type;

endpackage

FILE: design/beat_detect_rate_calc_top.sv
// Beat detector with hysteresis thresholds and windowed heart-rate divider.
//
// Usage:
//   req_ channel takes one signed 16-bit sample word per handshake; every
//   sample yields exactly one rsp_ word (beat, beat_ok, rate_ready, rate).
//   csr_ channel writes the four threshold/limit registers; write only when
//   the block is idle. csr_ready is always high.
// Timing:
//   A sample that completes no beat passes the span and done states on its
//   way to its rsp_ word; a beat also passes the window state; a beat that
//   closes a rate window also runs the divider state for the 15 quotient
//   steps of the shared subtractor, one per cycle. req_ready is high only in
//   the idle state, so one sample is in flight at a time.
// Reset:
//   Synchronous reset restores default thresholds and limits, disarms the
//   detector and clears the tick count and window beat count.
// Stall:
//   The rsp_ output register holds while rsp_ready is low; one more sample
//   may be accepted and finished, and then waits until the register drains.
module beat_detect_rate_calc_top #(
   parameter int BEATS_PER_WINDOW = bdrc_pkg::DEF_BEATS_PER_WIN,
   parameter int TICK_BITS        = bdrc_pkg::DEF_TICK_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [bdrc_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_beat,
   output logic                                 rsp_beat_ok,
   output logic                                 rsp_rate_ready,
   output logic [bdrc_pkg::RATE_W-1:0]          rsp_rate,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bdrc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bdrc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import bdrc_pkg::*;

   localparam int BEAT_W  = $clog2(BEATS_PER_WINDOW + 1);
   localparam int CNT_W   = $clog2(RATE_W);
   localparam int ALU_W   = TICK_BITS + 1;
   localparam logic [RATE_W-1:0] RATE_NUM = RATE_W'(RATE_NUMERATOR);

   state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0]   upper_ff, upper_in;
   logic signed [SAMPLE_W-1:0]   lower_ff, lower_in;
   logic [CSR_DATA_W-1:0]        min_ff, min_in;
   logic [CSR_DATA_W-1:0]        max_ff, max_in;

   logic signed [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic                         armed_ff, armed_in;
   logic [TICK_BITS-1:0]         tick_ff, tick_in;
   logic [TICK_BITS-1:0]         arm_tick_ff, arm_tick_in;
   logic [TICK_BITS-1:0]         win_start_ff, win_start_in;
   logic [BEAT_W-1:0]            beats_ff, beats_in;
   logic [TICK_BITS-1:0]         span_ff, span_in;
   logic [TICK_BITS-1:0]         divisor_ff, divisor_in;
   logic [ALU_W-1:0]             rem_ff, rem_in;
   logic [RATE_W-1:0]            quot_ff, quot_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;

   result_type                   pend_ff, pend_in;
   result_type                   out_ff, out_in;
   logic                         out_valid_ff, out_valid_in;

   logic [ALU_W-1:0]             alu_a, alu_b;
   logic [ALU_W:0]               alu_diff;
   logic                         alu_borrow;
   logic [ALU_W-1:0]             div_shifted;
   logic                         beat_cond;
   logic                         arm_cond;
   logic                         span_ok;

   // shared subtractor
   assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow = alu_diff[ALU_W];

   assign div_shifted = {rem_ff[TICK_BITS-1:0], RATE_NUM[cnt_ff]};
   assign beat_cond   = armed_ff && (sample_ff < lower_ff);
   assign arm_cond    = !armed_ff && (sample_ff > upper_ff);
   assign span_ok     = (span_ff >= TICK_BITS'(min_ff)) && (span_ff <= TICK_BITS'(max_ff));

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = out_valid_ff;
   assign rsp_beat       = out_ff.beat;
   assign rsp_beat_ok    = out_ff.beat_ok;
   assign rsp_rate_ready = out_ff.rate_ready;
   assign rsp_rate       = out_ff.rate;

   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_UPPER_THRESHOLD: upper_in = csr_data;
            CSR_LOWER_THRESHOLD: lower_in = csr_data;
            CSR_MIN_HIGH_TICKS:  min_in   = csr_data;
            CSR_MAX_HIGH_TICKS:  max_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      armed_in     = armed_ff;
      tick_in      = tick_ff;
      arm_tick_in  = arm_tick_ff;
      win_start_in = win_start_ff;
      beats_in     = beats_ff;
      span_in      = span_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      alu_a        = '0;
      alu_b        = '0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               tick_in   = tick_ff + 1'b1;
               state_in  = ST_SPAN;
            end
         end
         ST_SPAN: begin
            alu_a   = {1'b0, tick_ff};
            alu_b   = {1'b0, arm_tick_ff};
            span_in = alu_diff[TICK_BITS-1:0];
            pend_in = '0;
            if (beat_cond) begin
               armed_in = 1'b0;
               state_in = ST_WIN;
            end else begin
               if (arm_cond) begin
                  armed_in    = 1'b1;
                  arm_tick_in = tick_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_WIN: begin
            alu_a           = {1'b0, tick_ff};
            alu_b           = {1'b0, win_start_ff};
            pend_in.beat    = 1'b1;
            pend_in.beat_ok = span_ok;
            state_in        = ST_DONE;
            if (beats_ff == '0) begin
               win_start_in = tick_ff;
               beats_in     = BEAT_W'(1);
            end else if (beats_ff == BEAT_W'(BEATS_PER_WINDOW)) begin
               win_start_in       = tick_ff;
               beats_in           = BEAT_W'(1);
               pend_in.rate_ready = 1'b1;
               if (alu_diff[TICK_BITS-1:0] == '0) begin
                  pend_in.rate = RATE_NUM;
               end else begin
                  divisor_in = alu_diff[TICK_BITS-1:0];
                  rem_in     = '0;
                  quot_in    = '0;
                  cnt_in     = CNT_W'(RATE_W - 1);
                  state_in   = ST_DIV;
               end
            end else begin
               beats_in = beats_ff + 1'b1;
            end
         end
         ST_DIV: begin
            alu_a   = div_shifted;
            alu_b   = {1'b0, divisor_ff};
            rem_in  = alu_borrow ? div_shifted : alu_diff[ALU_W-1:0];
            quot_in = {quot_ff[RATE_W-2:0], !alu_borrow};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               pend_in.rate = {quot_ff[RATE_W-2:0], !alu_borrow};
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upper_ff     <= UPPER_RESET;
         lower_ff     <= LOWER_RESET;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         armed_ff     <= 1'b0;
         tick_ff      <= '0;
         arm_tick_ff  <= '0;
         beats_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         armed_ff     <= armed_in;
         tick_ff      <= tick_in;
         arm_tick_ff  <= arm_tick_in;
         beats_ff     <= beats_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      win_start_ff <= win_start_in;
      span_ff      <= span_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      cnt_ff       <= cnt_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
   end

endmodule
